FILE: rtl/nndr_pkg.sv
package nndr_pkg;

	localparam int DIM_W = 13;
	localparam int POS_W = 12;
	localparam int PIX_W = 8;
	localparam int DVD_W = 21;
	localparam int CNT_W = 5;
	localparam int ROW_STEP_W = 4;
	localparam int ROW_REM_W = 9;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [DIM_W-1:0] TARGET_ROWS = 13'd480;
	localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
	localparam logic [DIM_W-1:0] RESET_WIDTH = 13'd640;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

	// h/480 is (h/32)/15, and x/15 is (x*137)>>11 for x up to 128
	localparam int ROW_SHIFT = 5;
	localparam int ROW_RECIP_SH = 11;
	localparam int ROW_PROD_W = ROW_RECIP_SH + ROW_STEP_W;
	localparam logic [ROW_PROD_W-1:0] ROW_RECIP = 15'd137;

	localparam logic REG_SRC_WIDTH = 1'b0;
	localparam logic REG_SRC_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		CALC_IDLE  = 4'b0001,
		CALC_LOAD  = 4'b0010,
		CALC_SCALE = 4'b0100,
		CALC_COL   = 4'b1000
	} nndr_calc_t;

	typedef struct packed {
		logic                  busy;
		logic [DIM_W-1:0]      scaled_width;
		logic [DIM_W-1:0]      col_step;
		logic [DIM_W-1:0]      col_rem;
		logic [ROW_STEP_W-1:0] row_step;
		logic [ROW_REM_W-1:0]  row_rem;
	} nndr_ratio_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > MAX_DIM) begin
			r = MAX_DIM;
		end
		return r;
	endfunction

endpackage

FILE: rtl/nndr_if.sv
interface nndr_in_if;
	import nndr_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] in_blue;
	logic [PIX_W-1:0] in_green;
	logic [PIX_W-1:0] in_red;
	logic [PIX_W-1:0] in_alpha;

	modport source (output valid, in_blue, in_green, in_red, in_alpha, input ready);
	modport sink (input valid, in_blue, in_green, in_red, in_alpha, output ready);
endinterface

interface nndr_out_if;
	import nndr_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_blue;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_alpha;
	logic             row_end;
	logic             frame_end;
	logic [DIM_W-1:0] out_width;
	logic [DIM_W-1:0] out_height;

	modport source (output valid, out_blue, out_green, out_red, out_alpha, row_end,
		frame_end, out_width, out_height, input ready);
	modport sink (input valid, out_blue, out_green, out_red, out_alpha, row_end,
		frame_end, out_width, out_height, output ready);
endinterface

FILE: rtl/nndr_ratio.sv
module nndr_ratio
	import nndr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIM_W-1:0] eff_w,
	input  logic [DIM_W-1:0] eff_h,
	output nndr_ratio_t      ratio
);

	nndr_calc_t          state_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [DIM_W-1:0]    dsr_q;
	logic [DIM_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIM_W-1:0]    sw_q;
	logic [DIM_W-1:0]    col_step_q;
	logic [DIM_W-1:0]    col_rem_q;
	logic [ROW_STEP_W-1:0] row_step_q;
	logic [ROW_REM_W-1:0]  row_rem_q;

	logic [DIM_W:0]      rem_shift;
	logic                qbit;
	logic [DIM_W-1:0]    rem_next;
	logic [DVD_W-1:0]    quo_next;
	logic                last_step;
	logic [DIM_W-1:0]    sw_next;
	logic [DVD_W-1:0]    area;
	logic [ROW_STEP_W-1:0] row_q;

	// one quotient bit per cycle, restoring
	assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
	assign qbit = rem_shift >= {1'b0, dsr_q};
	assign rem_next = qbit ? DIM_W'(rem_shift - {1'b0, dsr_q}) : rem_shift[DIM_W-1:0];
	assign quo_next = {dvd_q[DVD_W-2:0], qbit};
	assign last_step = cnt_q == CNT_W'(DVD_W - 1);
	assign sw_next = (eff_h <= TARGET_ROWS) ? eff_w : quo_next[DIM_W-1:0];
	assign area = DVD_W'(eff_w * TARGET_ROWS);

	// row step by reciprocal multiply
	assign row_q = ROW_STEP_W'((ROW_PROD_W'(eff_h[DIM_W-1:ROW_SHIFT]) * ROW_RECIP) >>
		ROW_RECIP_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CALC_LOAD;
			cnt_q <= '0;
		end else if (start) begin
			state_q <= CALC_LOAD;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				CALC_IDLE: begin
					state_q <= CALC_IDLE;
				end
				CALC_LOAD: begin
					state_q <= CALC_SCALE;
					cnt_q <= '0;
				end
				CALC_SCALE, CALC_COL: begin
					cnt_q <= last_step ? '0 : cnt_q + CNT_W'(1);
					if (last_step) begin
						state_q <= (state_q == CALC_SCALE) ? CALC_COL : CALC_IDLE;
					end
				end
				default: begin
					state_q <= CALC_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CALC_LOAD) begin
			dvd_q <= area;
			dsr_q <= eff_h;
			rem_q <= '0;
			row_step_q <= row_q;
			row_rem_q <= ROW_REM_W'(eff_h - (DIM_W'(row_q) * TARGET_ROWS));
		end else if (state_q != CALC_IDLE) begin
			if (last_step) begin
				rem_q <= '0;
				if (state_q == CALC_SCALE) begin
					sw_q <= sw_next;
					dvd_q <= DVD_W'(eff_w);
					dsr_q <= sw_next;
				end else begin
					col_step_q <= quo_next[DIM_W-1:0];
					col_rem_q <= rem_next;
				end
			end else begin
				dvd_q <= quo_next;
				rem_q <= rem_next;
			end
		end
	end

	assign ratio.busy = state_q != CALC_IDLE;
	assign ratio.scaled_width = sw_q;
	assign ratio.col_step = col_step_q;
	assign ratio.col_rem = col_rem_q;
	assign ratio.row_step = row_step_q;
	assign ratio.row_rem = row_rem_q;

endmodule

FILE: rtl/nearest_neighbor_downscale_rows.sv
// Nearest-neighbor row/column decimator for a raster BGRA pixel stream.
// pix_in (sink) takes one source pixel per request, left to right, top to
// bottom; pix_out (source) gives the picked pixels with row_end, frame_end
// and the output frame size. Source frames up to 480 rows pass through
// unchanged; taller ones are scaled to 480 rows and a width of
// floor(width*480/height), which may be zero (nothing is emitted then).
// The APB port holds source_width at 0x0 and source_height at 0x4.
// An accepted pixel's result is on pix_out in the next cycle.
// Throughput is one pixel per cycle while the divider is idle and the
// receiver keeps up: per-pixel work is counter updates and compares, and
// the output register takes a new result while the old one is being
// handed over. After reset, and after every register write, a shared
// bit-serial divider works out the width ratio and column step while the
// row step comes from a reciprocal multiply; pix_in.ready stays low until
// the divider is done and all position counters restart at a frame start.
// When the receiver stalls, the result waits in the output register and
// pix_in.ready drops until it is taken.
module nearest_neighbor_downscale_rows
	import nndr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	nndr_in_if.sink           pix_in,
	nndr_out_if.source        pix_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [DIM_W-1:0] src_width_q;
	logic [DIM_W-1:0] src_height_q;
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;
	logic             cfg_wr;
	nndr_ratio_t      ratio;

	logic [POS_W-1:0] src_col_q;
	logic [POS_W-1:0] src_row_q;
	logic [DIM_W-1:0] next_row_pick_q;
	logic [DIM_W-1:0] row_frac_q;
	logic [DIM_W-1:0] dest_row_q;
	logic [DIM_W-1:0] next_col_pick_q;
	logic [DIM_W-1:0] col_frac_q;
	logic [DIM_W-1:0] dest_col_q;

	logic             out_valid_q;
	logic [PIX_W-1:0] blue_q;
	logic [PIX_W-1:0] green_q;
	logic [PIX_W-1:0] red_q;
	logic [PIX_W-1:0] alpha_q;
	logic             row_end_q;
	logic             frame_end_q;
	logic [DIM_W-1:0] out_width_q;
	logic [DIM_W-1:0] out_height_q;

	logic             in_acc;
	logic             passthrough;
	logic             last_col;
	logic             last_row;
	logic             row_hit;
	logic             pick;
	logic             emit;
	logic             ds_row_end;
	logic [DIM_W:0]   col_sum;
	logic             col_carry;
	logic [DIM_W:0]   row_sum;
	logic             row_carry;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_SRC_HEIGHT) ? APB_DW'(src_height_q) : APB_DW'(src_width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= RESET_WIDTH;
			src_height_q <= RESET_HEIGHT;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SRC_WIDTH) begin
				src_width_q <= pwdata[DIM_W-1:0];
			end else begin
				src_height_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	assign eff_w = eff_dim(src_width_q);
	assign eff_h = eff_dim(src_height_q);

	nndr_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr),
		.eff_w  (eff_w),
		.eff_h  (eff_h),
		.ratio  (ratio)
	);

	// pick logic
	assign pix_in.ready = !ratio.busy && (!out_valid_q || pix_out.ready);
	assign in_acc = pix_in.valid && pix_in.ready;

	assign passthrough = eff_h <= TARGET_ROWS;
	assign last_col = ({1'b0, src_col_q} + DIM_W'(1)) >= eff_w;
	assign last_row = ({1'b0, src_row_q} + DIM_W'(1)) >= eff_h;
	assign row_hit = (dest_row_q < TARGET_ROWS) && ({1'b0, src_row_q} == next_row_pick_q);
	assign pick = (ratio.scaled_width != '0) && row_hit &&
		(dest_col_q < ratio.scaled_width) && ({1'b0, src_col_q} == next_col_pick_q);
	assign emit = passthrough || pick;
	assign ds_row_end = (dest_col_q + DIM_W'(1)) == ratio.scaled_width;

	assign col_sum = {1'b0, col_frac_q} + {1'b0, ratio.col_rem};
	assign col_carry = col_sum >= {1'b0, ratio.scaled_width};
	assign row_sum = {1'b0, row_frac_q} + (DIM_W+1)'(ratio.row_rem);
	assign row_carry = row_sum >= {1'b0, TARGET_ROWS};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			next_row_pick_q <= '0;
			row_frac_q <= '0;
			dest_row_q <= '0;
			next_col_pick_q <= '0;
			col_frac_q <= '0;
			dest_col_q <= '0;
		end else if (cfg_wr) begin
			src_col_q <= '0;
			src_row_q <= '0;
			next_row_pick_q <= '0;
			row_frac_q <= '0;
			dest_row_q <= '0;
			next_col_pick_q <= '0;
			col_frac_q <= '0;
			dest_col_q <= '0;
		end else if (in_acc) begin
			if (!passthrough && pick) begin
				dest_col_q <= dest_col_q + DIM_W'(1);
				next_col_pick_q <= next_col_pick_q + ratio.col_step + DIM_W'(col_carry);
				col_frac_q <= col_carry ? DIM_W'(col_sum - {1'b0, ratio.scaled_width}) :
					col_sum[DIM_W-1:0];
			end
			if (!passthrough && last_col && row_hit) begin
				dest_row_q <= dest_row_q + DIM_W'(1);
				next_row_pick_q <= next_row_pick_q + DIM_W'(ratio.row_step) + DIM_W'(row_carry);
				row_frac_q <= row_carry ? DIM_W'(row_sum - {1'b0, TARGET_ROWS}) :
					row_sum[DIM_W-1:0];
			end
			if (last_col) begin
				src_col_q <= '0;
				next_col_pick_q <= '0;
				col_frac_q <= '0;
				dest_col_q <= '0;
				if (last_row) begin
					src_row_q <= '0;
					next_row_pick_q <= '0;
					row_frac_q <= '0;
					dest_row_q <= '0;
				end else begin
					src_row_q <= src_row_q + POS_W'(1);
				end
			end else begin
				src_col_q <= src_col_q + POS_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= emit;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			blue_q <= pix_in.in_blue;
			green_q <= pix_in.in_green;
			red_q <= pix_in.in_red;
			alpha_q <= pix_in.in_alpha;
			if (passthrough) begin
				row_end_q <= last_col;
				frame_end_q <= last_col && last_row;
				out_width_q <= eff_w;
				out_height_q <= eff_h;
			end else begin
				row_end_q <= ds_row_end;
				frame_end_q <= ds_row_end && ((dest_row_q + DIM_W'(1)) == TARGET_ROWS);
				out_width_q <= ratio.scaled_width;
				out_height_q <= TARGET_ROWS;
			end
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.out_blue = blue_q;
	assign pix_out.out_green = green_q;
	assign pix_out.out_red = red_q;
	assign pix_out.out_alpha = alpha_q;
	assign pix_out.row_end = row_end_q;
	assign pix_out.frame_end = frame_end_q;
	assign pix_out.out_width = out_width_q;
	assign pix_out.out_height = out_height_q;

`ifndef ASSERT_OFF
	a_write_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !pix_in.ready)
		else $error("pixel request accepted right after a register write");

	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.frame_end) |-> pix_out.row_end)
		else $error("frame end without row end");

	a_dest_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!passthrough && !ratio.busy) |-> (dest_col_q <= ratio.scaled_width))
		else $error("output column past scaled width");
`endif

endmodule
